>>> hdl/ofd_pkg.sv
package ofd_pkg;

   localparam int SEEN_DEPTH = 64;
   localparam int ADDR_W     = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int FILL_W     = $clog2(SEEN_DEPTH + 1);
   localparam int COUNT_W    = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] MODE_REMOVE = 2'd0;
   localparam logic [1:0] MODE_KEEP_K = 2'd1;
   localparam logic [1:0] MODE_DEDUP  = 2'd2;

   localparam logic [1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [1:0] CSR_TARGET_VALUE = 2'd1;
   localparam logic [1:0] CSR_KEEP_COUNT   = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] target;
      logic [15:0] keep_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] value;
      logic        keep;
      logic        full;
      logic        last;
   } result_type;

endpackage

>>> hdl/occurrence_filter_dedup.sv
// In modes 0, 1 and 3 an item passes from accept through the engine FINISH
// state and the output register to rsp_valid; mode 2 first scans the seen
// table, one compare per cycle, over fill stored values (0..64). A new item is
// accepted only after the last one has left the engine for the output register.
// Reset (synchronous, active high) clears state, config, rsp_valid, count and fill; the
// seen table is not cleared since only entries below fill are read.
module occurrence_filter_dedup
   import ofd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_item_value,
   input  logic               req_item_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_keep,
   output logic               rsp_table_full,
   output logic               rsp_out_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   logic [1:0]  mode_ff;
   logic [31:0] target_ff;
   logic [15:0] keepk_ff;
   cfg_type     cfg;

   logic              res_valid, res_ready;
   result_type        res;
   result_type        out_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [31:0]       mem_wr_data, mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_REMOVE;
         target_ff <= '0;
         keepk_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_MODE:  mode_ff   <= csr_data[1:0];
            CSR_TARGET_VALUE: target_ff <= csr_data;
            CSR_KEEP_COUNT:   keepk_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   assign cfg.mode       = mode_ff;
   assign cfg.target     = target_ff;
   assign cfg.keep_count = keepk_ff;

   ofd_seen_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ofd_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_value    (req_item_value),
      .in_last     (req_item_last),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register frees when its item is taken this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         out_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = out_ff.value;
   assign rsp_keep       = out_ff.keep;
   assign rsp_table_full = out_ff.full;
   assign rsp_out_last   = out_ff.last;

endmodule

>>> hdl/ofd_seen_ram.sv
module ofd_seen_ram
   import ofd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data
);

   logic [31:0] mem_ff [SEEN_DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ofd_engine.sv
module ofd_engine
   import ofd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [31:0]       in_value,
   input  logic              in_last,
   output logic              res_valid,
   input  logic              res_ready,
   output result_type        res,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [31:0]       mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [31:0]       mem_rd_data
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        value_ff, value_in;
   logic               last_ff, last_in;
   logic [FILL_W-1:0]  idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               found_ff, found_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic               match_now;
   logic               is_target;
   logic [COUNT_W-1:0] count_inc;
   logic               keep;
   logic               full;
   logic               store;
   logic               leave;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == ST_IDLE);
   assign match_now = pend_ff && (mem_rd_data == value_ff);
   assign is_target = (value_ff == cfg.target);
   assign count_inc = (count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign leave     = (state_ff == ST_FINISH) && res_ready;

   // scan issues one read per cycle; its compare lands in the next cycle
   assign mem_rd_en   = (state_ff == ST_SCAN) && (idx_ff < fill_ff) && !match_now;
   assign mem_rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      keep  = 1'b1;
      full  = 1'b0;
      store = 1'b0;
      unique case (cfg.mode)
         MODE_REMOVE: keep = !is_target;
         MODE_KEEP_K: begin
            if (is_target) begin
               keep = (count_inc <= {1'b0, cfg.keep_count});
            end
         end
         MODE_DEDUP: begin
            if (found_ff) begin
               keep = 1'b0;
            end else if (fill_ff < FILL_W'(SEEN_DEPTH)) begin
               store = 1'b1;
            end else begin
               full = 1'b1;
            end
         end
         default: keep = 1'b1;
      endcase
   end

   assign mem_wr_en   = leave && store;
   assign mem_wr_addr = fill_ff[ADDR_W-1:0];
   assign mem_wr_data = value_ff;

   assign res_valid  = (state_ff == ST_FINISH);
   assign res.value  = value_ff;
   assign res.keep   = keep;
   assign res.full   = full;
   assign res.last   = last_ff;

   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      pend_in  = 1'b0;
      found_in = found_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = in_value;
               last_in  = in_last;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (cfg.mode == MODE_DEDUP) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            pend_in = mem_rd_en;
            if (mem_rd_en) begin
               idx_in = idx_ff + FILL_W'(1);
            end
            if (match_now || (idx_ff == fill_ff)) begin
               found_in = match_now;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (leave) begin
               if (cfg.mode == MODE_KEEP_K && is_target) begin
                  count_in = count_inc;
               end
               if (store) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (last_ff) begin
                  count_in = '0;
                  fill_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      found_ff <= found_in;
   end

endmodule

>>> hdl/ofd_checker.sv
module ofd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_value,
   input logic        rsp_keep,
   input logic        rsp_table_full,
   input logic        rsp_out_last
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_keep) && $stable(rsp_out_last))
      else $error("rsp item changed while stalled");

   // one item at a time: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high the cycle after accept");

   // a full table only ever keeps the value
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> rsp_keep)
      else $error("table_full item dropped");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind occurrence_filter_dedup ofd_checker u_ofd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_value  (rsp_out_value),
   .rsp_keep       (rsp_keep),
   .rsp_table_full (rsp_table_full),
   .rsp_out_last   (rsp_out_last)
);
